### rtl/ursg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ursg_pkg: shared types and constants for the ultrasonic ranger
// Phase codes, the word passed from front to back, result word, segment table.
// ----------------------------------------------------------------------------
package ursg_pkg;

  localparam int unsigned TRIG_TICKS = 20;
  localparam int unsigned TT_W       = 7;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned DIST_W     = 14;
  localparam int unsigned SEG_W      = 8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // back end: stage count between queue and output register
  localparam int unsigned NSTG = 10;

  // reciprocal constants for division by constants
  localparam logic [21:0] RCP_100_L  = 22'd2684355;  // 2^28/100, x < 2^21
  localparam logic [16:0] RCP_5      = 17'd104858;   // 2^19/5,   x < 2^16
  localparam logic [14:0] RCP_1000   = 15'd16778;    // 2^24/1000, x < 2^14
  localparam logic [10:0] RCP_100_S  = 11'd1311;     // 2^17/100, x < 1000
  localparam logic [7:0]  RCP_10     = 8'd205;       // 2^11/10,  x < 100

  localparam logic [SEG_W-1:0]   SEG_DP    = 8'h01;
  localparam logic [4*SEG_W-1:0] SEG_RESET = 32'hfcfcfdfc;

  typedef enum logic [1:0] {
    PH_TRIG  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_COUNT = 2'd2
  } phase_t;

  // classified word, front to back
  typedef struct packed {
    logic             trig;
    logic             done;
    logic             rx;
    logic [CNT_W-1:0] cnt;
    logic             led;
  } item_t;

  // per-stage control in the back end
  typedef struct packed {
    logic vld;
    logic trig;
    logic done;
    logic rx;
    logic led;
  } ctl_t;

  typedef struct packed {
    logic              trig;
    logic              done;
    logic              rx;
    logic [DIST_W-1:0] dist_mm;
    logic [SEG_W-1:0]  seg_th;
    logic [SEG_W-1:0]  seg_hu;
    logic [SEG_W-1:0]  seg_te;
    logic [SEG_W-1:0]  seg_un;
    logic              led;
  } res_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] dig);
    logic [SEG_W-1:0] s;
    case (dig)
      4'd0:    s = 8'hfc;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hda;
      4'd3:    s = 8'hf2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hb6;
      4'd6:    s = 8'hbe;
      4'd7:    s = 8'he0;
      4'd8:    s = 8'hfe;
      4'd9:    s = 8'hf6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### rtl/ultrasonic_range_to_segments_top.sv
// A pushed word reaches the out_ ports through the queue and the pipeline.
// Throughput: one word per cycle; push is refused only while the 4-word queue
// between the sequencer and the scaling pipeline is full (result side stalled).
// Reset (rst_n low, synchronous): trigger phase, counters and indicator clear,
// queue and pipeline empty, held segments show distance zero, timeout = 25.
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_range_to_segments_top: ultrasonic ranger with segment encoding
// Sequencer front end, word queue, scaling and digit pipeline back end.
// ----------------------------------------------------------------------------
module ultrasonic_range_to_segments_top
  import ursg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               in_echo_level,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    out_trig_out,
  output logic                    out_measure_done,
  output logic                    out_echo_received,
  output logic [DIST_W-1:0]       out_distance_mm,
  output logic [SEG_W-1:0]        out_seg_thousands,
  output logic [SEG_W-1:0]        out_seg_hundreds,
  output logic [SEG_W-1:0]        out_seg_tens,
  output logic [SEG_W-1:0]        out_seg_units,
  output logic                    out_indicator_led,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_timeout_limit_high
);

  logic [LIMIT_W-1:0] limit_r;
  logic               tick_en;
  item_t              f_item;
  item_t              q_data;
  logic               q_empty;
  logic               q_rd;
  res_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_W'(25);
    end else if (cfg_we) begin
      limit_r <= cfg_timeout_limit_high;
    end
  end

  assign tick_en = push && !full;

  ursg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (tick_en),
    .echo    (in_echo_level),
    .limit   (limit_r),
    .item    (f_item)
  );

  ursg_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tick_en),
    .wr_data (f_item),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  ursg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign out_trig_out      = res.trig;
  assign out_measure_done  = res.done;
  assign out_echo_received = res.rx;
  assign out_distance_mm   = res.dist_mm;
  assign out_seg_thousands = res.seg_th;
  assign out_seg_hundreds  = res.seg_hu;
  assign out_seg_tens      = res.seg_te;
  assign out_seg_units     = res.seg_un;
  assign out_indicator_led = res.led;

`ifndef NO_ASSERTIONS
  // a finishing tick is never a trigger tick
  a_done_not_trig: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_trig_out && out_measure_done))
    else $error("measure_done on a trigger tick");

  // distance and echo flag only on a finishing tick
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_measure_done) |-> (out_distance_mm == '0 && !out_echo_received))
    else $error("distance or echo flag outside a finishing tick");

  // a timed-out measurement reports zero distance
  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_measure_done && !out_echo_received) |-> (out_distance_mm == '0))
    else $error("nonzero distance on timeout");

  // tens byte always carries the decimal point
  a_tens_dp: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_seg_tens[0])
    else $error("decimal point missing on tens digit");
`endif

endmodule
`default_nettype wire

### rtl/ursg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ursg_front: trigger / echo sequencer
// Steps the ranging phases once per accepted tick and classifies the tick.
// ----------------------------------------------------------------------------
module ursg_front
  import ursg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               tick_en,
  input  wire logic               echo,
  input  wire logic [LIMIT_W-1:0] limit,
  output item_t                   item
);

  phase_t            phase_r, phase_nxt;
  logic [TT_W-1:0]   tt_r, tt_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              led_r, led_nxt;

  logic              trig_ph;
  logic              counting;
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W:0]    cnt_inc;
  logic [CNT_W-1:0]  cnt_sat;
  logic [CNT_W-1:0]  threshold;
  logic [TT_W-1:0]   tt_inc;
  logic              trig_end;
  logic              hit;
  logic              done;
  logic              rx;

  // next state
  always_comb begin
    case (phase_r)
      PH_WAIT: begin
        if (!echo) begin
          phase_nxt = PH_WAIT;
        end else if (done) begin
          phase_nxt = PH_TRIG;
        end else begin
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        phase_nxt = done ? PH_TRIG : PH_COUNT;
      end
      default: begin
        phase_nxt = trig_end ? PH_WAIT : PH_TRIG;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    trig_ph   = (phase_r != PH_WAIT) && (phase_r != PH_COUNT);
    counting  = (phase_r == PH_COUNT) || ((phase_r == PH_WAIT) && echo);
    cnt_base  = (phase_r == PH_WAIT) ? '0 : cnt_r;
    cnt_inc   = {1'b0, cnt_base} + {{CNT_W{1'b0}}, 1'b1};
    cnt_sat   = cnt_inc[CNT_W] ? {CNT_W{1'b1}} : cnt_inc[CNT_W-1:0];
    threshold = {limit, 8'h00};
    tt_inc    = tt_r + TT_W'(1);
    trig_end  = tt_inc >= TT_W'(TRIG_TICKS);
    hit       = echo && (cnt_sat >= threshold);
    done      = counting && (!echo || hit);
    rx        = counting && !echo;

    if (trig_ph) begin
      tt_nxt = trig_end ? '0 : tt_inc;
    end else if (done) begin
      tt_nxt = '0;
    end else begin
      tt_nxt = tt_r;
    end

    if (done) begin
      cnt_nxt = '0;
    end else if (counting) begin
      cnt_nxt = cnt_sat;
    end else begin
      cnt_nxt = cnt_r;
    end

    led_nxt = led_r ^ (done && !rx);

    item.trig = trig_ph;
    item.done = done;
    item.rx   = rx;
    item.cnt  = cnt_base;
    item.led  = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TRIG;
      tt_r    <= '0;
      cnt_r   <= '0;
      led_r   <= 1'b0;
    end else if (tick_en) begin
      phase_r <= phase_nxt;
      tt_r    <= tt_nxt;
      cnt_r   <= cnt_nxt;
      led_r   <= led_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/ursg_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ursg_fifo: short word queue between front and back
// Register-based, first-word fall-through read.
// ----------------------------------------------------------------------------
module ursg_fifo
  import ursg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_en,
  input  wire item_t wr_data,
  input  wire logic  rd_en,
  output item_t      rd_data,
  output logic       full,
  output logic       empty
);

  item_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wp_r, wp_nxt;
  logic [FIFO_AW-1:0]  rp_r, rp_nxt;
  logic [FIFO_AW:0]    cnt_r, cnt_nxt;
  logic                do_wr;
  logic                do_rd;

  always_comb begin
    full    = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
    empty   = cnt_r == '0;
    do_wr   = wr_en && !full;
    do_rd   = rd_en && !empty;
    wp_nxt  = do_wr ? wp_r + FIFO_AW'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + FIFO_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
    rd_data = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### rtl/ursg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ursg_back: distance scaling, decimal split and segment encoding
// Stall-as-one pipeline from the queue head to the output register.
// ----------------------------------------------------------------------------
module ursg_back
  import ursg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire item_t q_data,
  input  wire logic  q_empty,
  output logic       q_rd,
  output res_t       res,
  output logic       res_empty,
  input  wire logic  res_pop
);

  ctl_t                ctl_r [NSTG];
  logic                adv;

  logic [20:0]         p1_r;
  logic [DIST_W-1:0]   d2_r;
  logic [17:0]         x3_r;
  logic [DIST_W-1:0]   d4_r, d5_r, d6_r, d7_r, d8_r, d9_r, d10_r;
  logic [4:0]          q5_r;
  logic [3:0]          th6_r, th7_r, th8_r, th9_r, th10_r;
  logic [9:0]          r6_r, r7_r;
  logic [3:0]          h7_r, h8_r, h9_r, h10_r;
  logic [6:0]          r8_r, r9_r;
  logic [3:0]          t9_r, t10_r;
  logic [3:0]          u10_r;

  logic [42:0]         prod2;
  logic [18:0]         prod3;
  logic [32:0]         prod4;
  logic [28:0]         prod5;
  logic [14:0]         sub6;
  logic [20:0]         prod7;
  logic [10:0]         sub8;
  logic [14:0]         prod9;
  logic [6:0]          sub10;

  res_t                res_r;
  logic                out_vld_r;
  logic [4*SEG_W-1:0]  last_seg_r;
  logic [4*SEG_W-1:0]  seg_new;
  logic [4*SEG_W-1:0]  seg_sel;

  always_comb begin
    adv       = !out_vld_r || res_pop;
    q_rd      = adv && !q_empty;
    res_empty = !out_vld_r;
    res       = res_r;

    prod2 = 43'(p1_r) * 43'(RCP_100_L);
    prod3 = 19'(d2_r) * 19'd21;
    prod4 = 33'(x3_r[17:2]) * 33'(RCP_5);
    prod5 = 29'(d4_r) * 29'(RCP_1000);
    sub6  = 15'(d5_r) - 15'(q5_r) * 15'd1000;
    prod7 = 21'(r6_r) * 21'(RCP_100_S);
    sub8  = 11'(r7_r) - 11'(h7_r) * 11'd100;
    prod9 = 15'(r8_r) * 15'(RCP_10);
    sub10 = r9_r - 7'(t9_r) * 7'd10;

    seg_new = {seg_of(th10_r), seg_of(h10_r), seg_of(t10_r) | SEG_DP, seg_of(u10_r)};
    seg_sel = ctl_r[NSTG-1].done ? seg_new : last_seg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        ctl_r[i] <= '0;
      end
      out_vld_r  <= 1'b0;
      last_seg_r <= SEG_RESET;
    end else if (adv) begin
      ctl_r[0] <= '{vld: !q_empty, trig: q_data.trig, done: q_data.done,
                    rx: q_data.rx, led: q_data.led};
      for (int i = 1; i < NSTG; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      out_vld_r <= ctl_r[NSTG-1].vld;
      if (ctl_r[NSTG-1].vld && ctl_r[NSTG-1].done) begin
        last_seg_r <= seg_new;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= q_data.rx ? 21'(q_data.cnt) * 21'd17 : '0;
      d2_r   <= prod2[41:28];                       // /100
      x3_r   <= prod3[17:0];                        // *21
      d4_r   <= prod4[32:19];                       // /4 then /5
      q5_r   <= prod5[28:24];                       // /1000
      d5_r   <= d4_r;
      th6_r  <= (q5_r >= 5'd10) ? 4'(q5_r - 5'd10) : q5_r[3:0];
      r6_r   <= sub6[9:0];
      d6_r   <= d5_r;
      th7_r  <= th6_r;
      h7_r   <= prod7[20:17];                       // /100
      r7_r   <= r6_r;
      d7_r   <= d6_r;
      th8_r  <= th7_r;
      h8_r   <= h7_r;
      r8_r   <= sub8[6:0];
      d8_r   <= d7_r;
      th9_r  <= th8_r;
      h9_r   <= h8_r;
      t9_r   <= prod9[14:11];                       // /10
      r9_r   <= r8_r;
      d9_r   <= d8_r;
      th10_r <= th9_r;
      h10_r  <= h9_r;
      t10_r  <= t9_r;
      u10_r  <= sub10[3:0];
      d10_r  <= d9_r;

      res_r.trig    <= ctl_r[NSTG-1].trig;
      res_r.done    <= ctl_r[NSTG-1].done;
      res_r.rx      <= ctl_r[NSTG-1].rx;
      res_r.dist_mm <= d10_r;
      res_r.seg_th  <= seg_sel[31:24];
      res_r.seg_hu  <= seg_sel[23:16];
      res_r.seg_te  <= seg_sel[15:8];
      res_r.seg_un  <= seg_sel[7:0];
      res_r.led     <= ctl_r[NSTG-1].led;
    end
  end

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: ultrasonic ranger with segment encoding
// Drives one echo sample per word and predicts every result word (trigger,
// finish flags, distance, held segments, indicator). Words are compared in
// order against the prediction. Covers timeout values 0, 1 and 200, an
// unbroken stretch with no idling, and random measurement sequences.
// ----------------------------------------------------------------------------
module tb_top;
  import ursg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20_000;
  localparam int unsigned DRAIN_WAIT  = 30;
  // segment bytes of digits 0..9, digit 0 in the top byte
  localparam logic [79:0] SEG_LUT = 80'hfc60daf266b6bee0fef6;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic                in_echo_level = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic                out_trig_out;
  logic                out_measure_done;
  logic                out_echo_received;
  logic [DIST_W-1:0]   out_distance_mm;
  logic [SEG_W-1:0]    out_seg_thousands;
  logic [SEG_W-1:0]    out_seg_hundreds;
  logic [SEG_W-1:0]    out_seg_tens;
  logic [SEG_W-1:0]    out_seg_units;
  logic                out_indicator_led;
  logic                cfg_we = 1'b0;
  logic [LIMIT_W-1:0]  cfg_timeout_limit_high = '0;

  // ranger state as predicted
  phase_t              seq_phase = PH_TRIG;
  logic [TT_W-1:0]     trig_cnt = '0;
  logic [CNT_W-1:0]    echo_ticks = '0;
  logic                led_lvl = 1'b0;
  logic [4*SEG_W-1:0]  held_segs = 32'hfcfcfdfc;
  logic [LIMIT_W-1:0]  limit_hi = 8'd25;

  res_t                pending_readings[$];
  res_t                got_word;
  res_t                want_word;
  bit                  no_idle = 1'b0;
  int unsigned         sent_ticks = 0;
  int unsigned         words_seen = 0;
  int unsigned         errors = 0;
  int unsigned         cycles = 0;

  ultrasonic_range_to_segments_top u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .push                   (push),
    .full                   (full),
    .in_echo_level          (in_echo_level),
    .empty                  (empty),
    .pop                    (pop),
    .out_trig_out           (out_trig_out),
    .out_measure_done       (out_measure_done),
    .out_echo_received      (out_echo_received),
    .out_distance_mm        (out_distance_mm),
    .out_seg_thousands      (out_seg_thousands),
    .out_seg_hundreds       (out_seg_hundreds),
    .out_seg_tens           (out_seg_tens),
    .out_seg_units          (out_seg_units),
    .out_indicator_led      (out_indicator_led),
    .cfg_we                 (cfg_we),
    .cfg_timeout_limit_high (cfg_timeout_limit_high)
  );

  always #5 clk = ~clk;

  function automatic logic [4*SEG_W-1:0] digit_segments(input logic [DIST_W-1:0] mm);
    int unsigned v;
    v = mm;
    return {SEG_LUT[8*(9-((v/1000)%10)) +: 8],
            SEG_LUT[8*(9-((v%1000)/100)) +: 8],
            SEG_LUT[8*(9-((v%100)/10)) +: 8] | SEG_DP,
            SEG_LUT[8*(9-(v%10)) +: 8]};
  endfunction

  // one echo sample in, one predicted result word out
  function automatic res_t range_step(input logic echo);
    res_t             r;
    logic [CNT_W:0]   c;
    logic [CNT_W-1:0] thr;
    longint unsigned  d;
    r   = '0;
    d   = 0;
    thr = {limit_hi, 8'h00};
    if (seq_phase != PH_WAIT && seq_phase != PH_COUNT) begin
      r.trig   = 1'b1;
      trig_cnt = trig_cnt + 1'b1;
      if (trig_cnt >= TRIG_TICKS) begin
        trig_cnt  = '0;
        seq_phase = PH_WAIT;
      end else begin
        seq_phase = PH_TRIG;
      end
    end else begin
      // the rising tick itself is counted
      if (seq_phase == PH_WAIT && echo) begin
        seq_phase  = PH_COUNT;
        echo_ticks = '0;
      end
      if (seq_phase == PH_COUNT) begin
        if (!echo) begin
          r.done = 1'b1;
          r.rx   = 1'b1;
          d = (64'(echo_ticks) * 17) / 100;
          d = (d * 126000) / 120000;
        end else begin
          c = echo_ticks + 1'b1;
          if (c > 17'h0ffff) c = 17'h0ffff;
          echo_ticks = c[CNT_W-1:0];
          if (c >= thr) begin
            r.done  = 1'b1;
            led_lvl = ~led_lvl;
          end
        end
        if (r.done) begin
          held_segs  = digit_segments(d[DIST_W-1:0]);
          seq_phase  = PH_TRIG;
          trig_cnt   = '0;
          echo_ticks = '0;
        end
      end
    end
    r.dist_mm = d[DIST_W-1:0];
    r.seg_th  = held_segs[31:24];
    r.seg_hu  = held_segs[23:16];
    r.seg_te  = held_segs[15:8];
    r.seg_un  = held_segs[7:0];
    r.led     = led_lvl;
    return r;
  endfunction

  task automatic send_tick(input logic echo);
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    in_echo_level <= echo;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_readings.push_back(range_step(echo));
    sent_ticks++;
  endtask

  task automatic wait_readings_out();
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic set_timeout_limit(input logic [LIMIT_W-1:0] v);
    wait_readings_out();
    cfg_we                 <= 1'b1;
    cfg_timeout_limit_high <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limit_hi = v;
  endtask

  // one measurement: finish the trigger, stay low, hold echo high, drop it
  task automatic run_ranging(input int unsigned gap, input int unsigned high_len,
                             input int unsigned trig_high_pct);
    while (seq_phase == PH_TRIG) send_tick($urandom_range(0, 99) < trig_high_pct);
    repeat (gap) send_tick(1'b0);
    repeat (high_len) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_reset_and_basic();
    // reset segments and timeout; echo high during trigger must be ignored
    run_ranging(3, 1, 100);
    run_ranging(0, 40, 0);
  endtask

  task automatic test_zero_limit();
    set_timeout_limit(8'd0);
    run_ranging(2, 2, 0);
    run_ranging(0, 1, 0);
  endtask

  task automatic test_short_limit();
    set_timeout_limit(8'd1);
    run_ranging(1, 255, 0);
    run_ranging(1, 256, 0);
  endtask

  task automatic test_long_range();
    no_idle = 1'b1;
    set_timeout_limit(8'd200);
    // both sides busy every cycle for a whole measurement
    run_ranging(0, 80, 0);
    wait_readings_out();
    no_idle = 1'b0;
  endtask

  task automatic test_random_ranging();
    logic [LIMIT_W-1:0] lims [5];
    int unsigned        pick;
    int unsigned        high_len;
    int unsigned        stop_at;
    lims[0] = 8'd1;
    lims[1] = 8'($urandom_range(2, 4));
    lims[2] = 8'd0;
    lims[3] = 8'($urandom_range(1, 200));
    lims[4] = 8'd200;
    foreach (lims[i]) begin
      set_timeout_limit(lims[i]);
      stop_at = sent_ticks + 20;
      while (sent_ticks < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          repeat ($urandom_range(1, 30)) send_tick(1'($urandom_range(0, 1)));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70) high_len = $urandom_range(1, 30);
          else if (pick < 92) high_len = $urandom_range(31, 100);
          else high_len = $urandom_range(250, 260);
          run_ranging($urandom_range(0, 8), high_len, $urandom_range(0, 50));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    pop <= no_idle || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      got_word.trig    = out_trig_out;
      got_word.done    = out_measure_done;
      got_word.rx      = out_echo_received;
      got_word.dist_mm = out_distance_mm;
      got_word.seg_th  = out_seg_thousands;
      got_word.seg_hu  = out_seg_hundreds;
      got_word.seg_te  = out_seg_tens;
      got_word.seg_un  = out_seg_units;
      got_word.led     = out_indicator_led;
      if (pending_readings.size() == 0) begin
        if (errors < 10) $display("tb_top: unexpected word %h", got_word);
        errors++;
      end else begin
        want_word = pending_readings.pop_front();
        if (got_word.trig !== want_word.trig || got_word.done !== want_word.done ||
            got_word.rx !== want_word.rx || got_word.dist_mm !== want_word.dist_mm ||
            got_word.seg_th !== want_word.seg_th || got_word.seg_hu !== want_word.seg_hu ||
            got_word.seg_te !== want_word.seg_te || got_word.seg_un !== want_word.seg_un ||
            got_word.led !== want_word.led) begin
          if (errors < 10) begin
            $display("tb_top: word %0d exp trig %b done %b rx %b dist %0d seg %h %h %h %h led %b",
                     words_seen, want_word.trig, want_word.done, want_word.rx,
                     want_word.dist_mm, want_word.seg_th, want_word.seg_hu,
                     want_word.seg_te, want_word.seg_un, want_word.led);
            $display("tb_top: word %0d got trig %b done %b rx %b dist %0d seg %h %h %h %h led %b",
                     words_seen, got_word.trig, got_word.done, got_word.rx,
                     got_word.dist_mm, got_word.seg_th, got_word.seg_hu,
                     got_word.seg_te, got_word.seg_un, got_word.led);
          end
          errors++;
        end
      end
      words_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_and_basic();
    test_zero_limit();
    test_short_limit();
    test_long_range();
    test_random_ranging();
    wait_readings_out();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ursg_pkg.sv
rtl/ursg_front.sv
rtl/ursg_fifo.sv
rtl/ursg_back.sv
rtl/ultrasonic_range_to_segments_top.sv
sim/tb_top.sv
